// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, disabled while the active-low reset is low.
`define DSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("splitter port check failed");

// Check a property on the standard clock and reset names.
`define DSS_ASSERT_STD(lbl, prop) \
  `DSS_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ===== design/dss_pkg.sv =====
// Shared types and constants of the delimiter string splitter.
`default_nettype none

package dss_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned DLEN_W      = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Split modes; the unused code behaves as per-byte mode
  localparam logic [MODE_W-1:0] MODE_LITERAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLANK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BYTE    = 2'd2;

  // Register indexes on the write port
  localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_LEN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_BYTES = 2'd2;

  // Blank characters
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

  // Reset value of the delimiter length register
  localparam logic [DLEN_W-1:0] DLEN_RESET = 4'd1;

  // Control flags of one queue entry
  typedef struct packed {
    logic has_cut;
    logic has_end;
    logic ovf;
  } seg_flags_t;

endpackage

`default_nettype wire

// ===== design/dss_front.sv =====
// Front end: accepts byte beats, tracks string state and classifies cuts.
`default_nettype none

module dss_front #(
  parameter int unsigned POSITION_WIDTH = 16,
  parameter int unsigned MAX_DELIMITER  = 8
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        in_valid_i,
  output logic                                             in_ready_o,
  input  wire logic [dss_pkg::BYTE_W-1:0]                  data_byte_i,
  input  wire logic                                        byte_present_i,
  input  wire logic                                        string_end_i,
  input  wire logic [dss_pkg::MODE_W-1:0]                  mode_i,
  input  wire logic [dss_pkg::DLEN_W-1:0]                  dlen_i,
  input  wire logic [MAX_DELIMITER*dss_pkg::BYTE_W-1:0]    delim_i,
  input  wire logic                                        q_full_i,
  output logic                                             push_o,
  output dss_pkg::seg_flags_t                              flags_o,
  output logic [POSITION_WIDTH-1:0]                        cut_start_o,
  output logic [POSITION_WIDTH-1:0]                        cut_len_o,
  output logic [POSITION_WIDTH-1:0]                        end_start_o,
  output logic [POSITION_WIDTH-1:0]                        end_len_o
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned WW = MAX_DELIMITER * dss_pkg::BYTE_W;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  logic [WW-1:0]                   recent_q, recent_d;
  logic [PW-1:0]                   pos_q, pos_d;
  logic [PW-1:0]                   start_q, start_d;
  logic                            ovf_q, ovf_d;

  logic                            accept;
  logic                            at_max;
  logic [PW-1:0]                   next_pos;
  logic                            ovf_mid;
  logic [WW+dss_pkg::BYTE_W-1:0]   shifted;
  logic [WW-1:0]                   recent_new;
  logic [dss_pkg::DLEN_W-1:0]      d_eff;
  logic [PW-1:0]                   d_wide;
  logic [MAX_DELIMITER-1:0]        match_vec;
  logic                            match;
  logic [PW-1:0]                   cnt;
  logic [PW-1:0]                   before_pos;
  logic [PW-1:0]                   blank_len;
  logic                            is_blank;
  logic                            cut;
  logic [PW-1:0]                   cut_len;
  logic [PW-1:0]                   start_mid;
  logic [PW-1:0]                   pos_mid;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Advance the position, saturating at the top of the offset range
  assign at_max   = (pos_q == POS_MAX);
  assign next_pos = at_max ? pos_q : pos_q + PW'(1);
  assign ovf_mid  = ovf_q || (byte_present_i && at_max);

  // Shift the new byte into the window, newest in the lowest byte
  assign shifted    = {recent_q, data_byte_i};
  assign recent_new = shifted[WW-1:0];

  // Clamp the delimiter length into 1..MAX_DELIMITER
  always_comb begin
    d_eff = dlen_i;
    if (dlen_i == '0) begin
      d_eff = dss_pkg::DLEN_W'(1);
    end else if (dlen_i > dss_pkg::DLEN_W'(MAX_DELIMITER)) begin
      d_eff = dss_pkg::DLEN_W'(MAX_DELIMITER);
    end
  end
  assign d_wide = PW'(d_eff);

  // Compare the window against the delimiter for every possible length
  always_comb begin
    for (int dd = 1; dd <= MAX_DELIMITER; dd++) begin
      match_vec[dd-1] = 1'b1;
      for (int k = 0; k < dd; k++) begin
        if (recent_new[dss_pkg::BYTE_W*k +: dss_pkg::BYTE_W] !=
            delim_i[dss_pkg::BYTE_W*(dd-1-k) +: dss_pkg::BYTE_W]) begin
          match_vec[dd-1] = 1'b0;
        end
      end
    end
  end

  // Pick the match for the active length
  always_comb begin
    match = 1'b0;
    for (int dd = 1; dd <= MAX_DELIMITER; dd++) begin
      if (d_eff == dss_pkg::DLEN_W'(dd)) begin
        match = match_vec[dd-1];
      end
    end
  end

  // Segment byte counts, saturating at zero
  assign cnt        = (next_pos > start_q) ? next_pos - start_q : '0;
  assign before_pos = (next_pos != '0) ? next_pos - PW'(1) : '0;
  assign blank_len  = (before_pos > start_q) ? before_pos - start_q : '0;
  assign is_blank   = (data_byte_i == dss_pkg::CH_SPACE) ||
                      (data_byte_i == dss_pkg::CH_TAB);

  // Classify the byte by split mode
  always_comb begin
    cut     = 1'b0;
    cut_len = cnt;
    case (mode_i)
      dss_pkg::MODE_LITERAL: begin
        cut     = (cnt >= d_wide) && match;
        cut_len = cnt - d_wide;
      end
      dss_pkg::MODE_BLANK: begin
        cut     = is_blank;
        cut_len = blank_len;
      end
      default: begin
        cut     = 1'b1;
        cut_len = cnt;
      end
    endcase
    cut = cut && byte_present_i;
  end

  // State as seen by the trailing segment
  assign start_mid = cut ? next_pos : start_q;
  assign pos_mid   = byte_present_i ? next_pos : pos_q;

  // Hand results to the queue
  assign push_o          = accept && (cut || string_end_i);
  assign flags_o.has_cut = cut;
  assign flags_o.has_end = string_end_i;
  assign flags_o.ovf     = ovf_mid;
  assign cut_start_o     = start_q;
  assign cut_len_o       = cut_len;
  assign end_start_o     = start_mid;
  assign end_len_o       = (pos_mid > start_mid) ? pos_mid - start_mid : '0;

  // Update string state; string end clears it
  always_comb begin
    recent_d = recent_q;
    pos_d    = pos_q;
    start_d  = start_q;
    ovf_d    = ovf_q;
    if (accept) begin
      if (string_end_i) begin
        recent_d = '0;
        pos_d    = '0;
        start_d  = '0;
        ovf_d    = 1'b0;
      end else if (byte_present_i) begin
        recent_d = recent_new;
        pos_d    = next_pos;
        start_d  = start_mid;
        ovf_d    = ovf_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      pos_q    <= '0;
      start_q  <= '0;
      ovf_q    <= 1'b0;
    end else begin
      recent_q <= recent_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/dss_queue.sv =====
// Short queue between the front end and the result stage.
`default_nettype none

module dss_queue #(
  parameter int unsigned DATA_W = 67
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      pop_data_o
);

  localparam int unsigned DEPTH = dss_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/dss_back.sv =====
// Result stage: turns queue entries into one or two output beats.
`default_nettype none

module dss_back #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_valid_i,
  output logic                           q_pop_o,
  input  wire dss_pkg::seg_flags_t       flags_i,
  input  wire logic [POSITION_WIDTH-1:0] cut_start_i,
  input  wire logic [POSITION_WIDTH-1:0] cut_len_i,
  input  wire logic [POSITION_WIDTH-1:0] end_start_i,
  input  wire logic [POSITION_WIDTH-1:0] end_len_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [POSITION_WIDTH-1:0]      segment_start_o,
  output logic [POSITION_WIDTH-1:0]      segment_length_o,
  output logic                           final_segment_o,
  output logic                           overflow_o
);

  localparam int unsigned PW = POSITION_WIDTH;

  logic          out_valid_q, out_valid_d;
  logic [PW-1:0] out_start_q, out_start_d;
  logic [PW-1:0] out_len_q, out_len_d;
  logic          out_final_q, out_final_d;
  logic          out_ovf_q, out_ovf_d;
  logic          pend_q, pend_d;
  logic [PW-1:0] pend_start_q, pend_start_d;
  logic [PW-1:0] pend_len_q, pend_len_d;
  logic          pend_ovf_q, pend_ovf_d;
  logic          load_ok;

  assign load_ok = !out_valid_q || out_ready_i;
  assign q_pop_o = load_ok && !pend_q && q_valid_i;

  // Load the output register: pending trailing segment first, then the queue
  always_comb begin
    out_valid_d  = out_valid_q;
    out_start_d  = out_start_q;
    out_len_d    = out_len_q;
    out_final_d  = out_final_q;
    out_ovf_d    = out_ovf_q;
    pend_d       = pend_q;
    pend_start_d = pend_start_q;
    pend_len_d   = pend_len_q;
    pend_ovf_d   = pend_ovf_q;
    if (load_ok) begin
      if (pend_q) begin
        out_valid_d = 1'b1;
        out_start_d = pend_start_q;
        out_len_d   = pend_len_q;
        out_final_d = 1'b1;
        out_ovf_d   = pend_ovf_q;
        pend_d      = 1'b0;
      end else if (q_valid_i) begin
        out_valid_d  = 1'b1;
        out_ovf_d    = flags_i.ovf;
        pend_start_d = end_start_i;
        pend_len_d   = end_len_i;
        pend_ovf_d   = flags_i.ovf;
        if (flags_i.has_cut) begin
          out_start_d = cut_start_i;
          out_len_d   = cut_len_i;
          out_final_d = 1'b0;
          pend_d      = flags_i.has_end;
        end else begin
          out_start_d = end_start_i;
          out_len_d   = end_len_i;
          out_final_d = 1'b1;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk_i) begin
    out_start_q  <= out_start_d;
    out_len_q    <= out_len_d;
    out_final_q  <= out_final_d;
    out_ovf_q    <= out_ovf_d;
    pend_start_q <= pend_start_d;
    pend_len_q   <= pend_len_d;
    pend_ovf_q   <= pend_ovf_d;
  end

  assign out_valid_o      = out_valid_q;
  assign segment_start_o  = out_start_q;
  assign segment_length_o = out_len_q;
  assign final_segment_o  = out_final_q;
  assign overflow_o       = out_ovf_q;

endmodule

`default_nettype wire

// ===== design/delimiter_string_splitter_unit.sv =====
// A result beat passes the queue and then the result register once its input beat
// is accepted. Throughput: one input beat per cycle while the queue is not full;
// an item that yields both a cut and the trailing segment gives two result beats,
// and a run of such items holds back the input once the two-entry queue fills.
// Reset: asynchronous, active low; clears string state, queue, result stage,
// and loads the registers with mode literal, delimiter length 1, delimiter 0.
`default_nettype none

module delimiter_string_splitter_unit #(
  parameter int unsigned POSITION_WIDTH = 16,
  parameter int unsigned MAX_DELIMITER  = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [dss_pkg::BYTE_W-1:0]         data_byte_i,
  input  wire logic                               byte_present_i,
  input  wire logic                               string_end_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [POSITION_WIDTH-1:0]               segment_start_o,
  output logic [POSITION_WIDTH-1:0]               segment_length_o,
  output logic                                    final_segment_o,
  output logic                                    overflow_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [dss_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [dss_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned PW     = POSITION_WIDTH;
  localparam int unsigned WW     = MAX_DELIMITER * dss_pkg::BYTE_W;
  localparam int unsigned FLAG_W = $bits(dss_pkg::seg_flags_t);
  localparam int unsigned QW     = FLAG_W + 4 * PW;

  logic [dss_pkg::MODE_W-1:0] mode_q;
  logic [dss_pkg::DLEN_W-1:0] dlen_q;
  logic [WW-1:0]              delim_q;

  logic                       q_full;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_valid;
  dss_pkg::seg_flags_t        push_flags;
  dss_pkg::seg_flags_t        pop_flags;
  logic [PW-1:0]              push_cut_start, push_cut_len;
  logic [PW-1:0]              push_end_start, push_end_len;
  logic [PW-1:0]              pop_cut_start, pop_cut_len;
  logic [PW-1:0]              pop_end_start, pop_end_len;
  logic [QW-1:0]              push_data;
  logic [QW-1:0]              pop_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= dss_pkg::MODE_LITERAL;
      dlen_q  <= dss_pkg::DLEN_RESET;
      delim_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dss_pkg::REG_SPLIT_MODE:  mode_q  <= cfg_wdata_i[dss_pkg::MODE_W-1:0];
        dss_pkg::REG_DELIM_LEN:   dlen_q  <= cfg_wdata_i[dss_pkg::DLEN_W-1:0];
        dss_pkg::REG_DELIM_BYTES: delim_q <= cfg_wdata_i[WW-1:0];
        default: ;
      endcase
    end
  end

  dss_front #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .MAX_DELIMITER  (MAX_DELIMITER)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .string_end_i   (string_end_i),
    .mode_i         (mode_q),
    .dlen_i         (dlen_q),
    .delim_i        (delim_q),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .flags_o        (push_flags),
    .cut_start_o    (push_cut_start),
    .cut_len_o      (push_cut_len),
    .end_start_o    (push_end_start),
    .end_len_o      (push_end_len)
  );

  // Pack and unpack queue entries
  assign push_data = {push_flags, push_cut_start, push_cut_len, push_end_start, push_end_len};
  assign {pop_flags, pop_cut_start, pop_cut_len, pop_end_start, pop_end_len} = pop_data;

  dss_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  dss_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_pop_o          (q_pop),
    .flags_i          (pop_flags),
    .cut_start_i      (pop_cut_start),
    .cut_len_i        (pop_cut_len),
    .end_start_i      (pop_end_start),
    .end_len_i        (pop_end_len),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .segment_start_o  (segment_start_o),
    .segment_length_o (segment_length_o),
    .final_segment_o  (final_segment_o),
    .overflow_o       (overflow_o)
  );

endmodule

`default_nettype wire

// ===== design/dss_checker.sv =====
// Port checker for the splitter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module dss_checker #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic [POSITION_WIDTH-1:0]          segment_start_o,
  input wire logic [POSITION_WIDTH-1:0]          segment_length_o,
  input wire logic                               final_segment_o,
  input wire logic                               overflow_o
);

  logic [2*POSITION_WIDTH+1:0] out_payload;

  assign out_payload = {segment_start_o, segment_length_o, final_segment_o, overflow_o};

  // Hold a stalled result beat
  `DSS_ASSERT_STD(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `DSS_ASSERT_STD(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_payload))

  // A full queue only builds up behind a waiting result beat
  `DSS_ASSERT_STD(a_busy_has_out, !in_ready_o |-> out_valid_o)

  // With no input and no result waiting, the input side opens next cycle
  `DSS_ASSERT(a_idle_ready, clk_i, rst_ni, !in_valid_i && !out_valid_o |=> in_ready_o)

endmodule

bind delimiter_string_splitter_unit dss_checker #(
  .POSITION_WIDTH (POSITION_WIDTH)
) u_dss_checker (.*);

`default_nettype wire

// ===== dv/tb_delimiter_string_splitter_unit.sv =====
// Self-checking testbench of the delimiter string splitter against a local predictor.
module tb_delimiter_string_splitter_unit;

  localparam int unsigned POS_W = 16;
  localparam int unsigned MAX_DELIM = 8;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [dss_pkg::MODE_W-1:0] MODE_RESERVED = 2'd3;
  localparam logic [dss_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [dss_pkg::BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [dss_pkg::BYTE_W-1:0] CH_LOWER_S = 8'h73;
  localparam int unsigned RANDOM_BEATS = 1750;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [dss_pkg::BYTE_W-1:0] data;
    logic                       present;
    logic                       last;
  } char_beat_t;

  typedef struct packed {
    logic [POS_W-1:0] offs;
    logic [POS_W-1:0] len;
    logic             fin;
    logic             ovf;
  } segment_t;

  // DUT ports
  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [dss_pkg::BYTE_W-1:0]      data_byte_i = '0;
  logic                            byte_present_i = 1'b0;
  logic                            string_end_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [POS_W-1:0]                segment_start_o;
  logic [POS_W-1:0]                segment_length_o;
  logic                            final_segment_o;
  logic                            overflow_o;
  logic                            cfg_we_i = 1'b0;
  logic [dss_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [dss_pkg::CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  // Register copies, at their reset values
  logic [dss_pkg::MODE_W-1:0]      mode_reg = dss_pkg::MODE_LITERAL;
  logic [dss_pkg::DLEN_W-1:0]      dlen_reg = dss_pkg::DLEN_RESET;
  logic [dss_pkg::CFG_DATA_W-1:0]  delim_reg = '0;

  // String state of the predictor
  logic [63:0]            win_bytes = '0;
  logic [POS_W-1:0]       next_offset = '0;
  logic [POS_W-1:0]       seg_origin = '0;
  logic                   ovf_flag = 1'b0;

  char_beat_t             beat_q[$];
  segment_t               seg_expect_q[$];

  logic                   in_taken = 1'b0;
  int unsigned            send_gap = 0;
  int unsigned            steady_in = 0;
  int unsigned            stall_left = 0;
  int unsigned            steady_out = 0;
  int unsigned            quiet_cycles = 0;
  int unsigned            bad_count = 0;

  delimiter_string_splitter_unit #(
    .POSITION_WIDTH(POS_W),
    .MAX_DELIMITER (MAX_DELIM)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .byte_present_i  (byte_present_i),
    .string_end_i    (string_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .segment_start_o (segment_start_o),
    .segment_length_o(segment_length_o),
    .final_segment_o (final_segment_o),
    .overflow_o      (overflow_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Segment predictor
  // ---------------------------------------------------------------------------

  function automatic logic [POS_W-1:0] sat_sub(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Clamp the length register into 1..MAX_DELIM
  function automatic int unsigned delim_width();
    if (dlen_reg == 0) return 1;
    if (dlen_reg > MAX_DELIM) return MAX_DELIM;
    return dlen_reg;
  endfunction

  function automatic void push_segment(input logic [POS_W-1:0] offs,
                                       input logic [POS_W-1:0] len, input logic fin);
    segment_t s;
    s.offs = offs;
    s.len  = len;
    s.fin  = fin;
    s.ovf  = ovf_flag;
    seg_expect_q.push_back(s);
  endfunction

  function automatic void predict_segments(input char_beat_t beat);
    logic [POS_W-1:0] origin;
    logic [POS_W-1:0] nxt;
    logic [POS_W-1:0] span;
    int unsigned      dl;
    int unsigned      k;
    logic             hit;
    if (beat.present) begin
      origin = seg_origin;
      // Hold the offset at its maximum once the string outgrows it
      if (next_offset == POS_MAX) begin
        ovf_flag = 1'b1;
        nxt = POS_MAX;
      end else begin
        nxt = next_offset + 1'b1;
      end
      win_bytes = {win_bytes[55:0], beat.data};
      span = sat_sub(nxt, origin);
      if (mode_reg == dss_pkg::MODE_LITERAL) begin
        // Newest byte sits against the last delimiter character
        dl = delim_width();
        hit = (span >= dl);
        for (k = 0; k < dl; k++) begin
          if (win_bytes[8*k +: 8] != delim_reg[8*(dl-1-k) +: 8]) hit = 1'b0;
        end
        if (hit) begin
          push_segment(origin, span - POS_W'(dl), 1'b0);
          seg_origin = nxt;
        end
      end else if (mode_reg == dss_pkg::MODE_BLANK) begin
        if (beat.data == dss_pkg::CH_SPACE || beat.data == dss_pkg::CH_TAB) begin
          push_segment(origin, sat_sub(sat_sub(nxt, POS_W'(1)), origin), 1'b0);
          seg_origin = nxt;
        end
      end else begin
        push_segment(origin, span, 1'b0);
        seg_origin = nxt;
      end
      next_offset = nxt;
    end
    // Close the string with its trailing segment and clear
    if (beat.last) begin
      push_segment(seg_origin, sat_sub(next_offset, seg_origin), 1'b1);
      win_bytes   = '0;
      next_offset = '0;
      seg_origin  = '0;
      ovf_flag    = 1'b0;
    end
  endfunction

  function automatic void check_segment();
    segment_t got;
    segment_t want;
    got = {segment_start_o, segment_length_o, final_segment_o, overflow_o};
    if (seg_expect_q.size() == 0) begin
      bad_count++;
      if (bad_count <= REPORT_LIMIT)
        $display("unexpected segment: start=%0d len=%0d final=%0b ovf=%0b",
                 got.offs, got.len, got.fin, got.ovf);
    end else begin
      want = seg_expect_q.pop_front();
      if (got.offs !== want.offs || got.len !== want.len ||
          got.fin !== want.fin || got.ovf !== want.ovf) begin
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
          $display("segment mismatch: exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                   want.offs, want.len, want.fin, want.ovf,
                   got.offs, got.len, got.fin, got.ovf);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(9, 40);
  endfunction

  // Hold the beat until taken, then advance after an optional gap
  always @(negedge clk_i) begin : drive_beats
    char_beat_t nb;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (steady_in > 0) steady_in--;
      else if ($urandom_range(0, 99) == 0) steady_in = $urandom_range(20, 100);
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (beat_q.size() > 0) begin
        nb = beat_q.pop_front();
        in_valid_i     <= 1'b1;
        data_byte_i    <= nb.data;
        byte_present_i <= nb.present;
        string_end_i   <= nb.last;
        send_gap = (steady_in > 0) ? 0 : pick_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin : drive_ready
    if (steady_out > 0) steady_out--;
    else if ($urandom_range(0, 199) == 0) steady_out = $urandom_range(20, 100);
    if (stall_left == 0 && steady_out == 0 && $urandom_range(0, 3) == 0)
      stall_left = pick_idle();
    out_ready_i <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  // Predict on input beats, check result beats, watch for a hang
  always @(posedge clk_i) begin : watch_beats
    char_beat_t cb;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        cb.data    = data_byte_i;
        cb.present = byte_present_i;
        cb.last    = string_end_i;
        predict_segments(cb);
      end
      if (out_valid_o && out_ready_i) check_segment();
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void queue_beat(input logic [dss_pkg::BYTE_W-1:0] data,
                                     input logic present, input logic last);
    char_beat_t cb;
    cb.data    = data;
    cb.present = present;
    cb.last    = last;
    beat_q.push_back(cb);
  endfunction

  function automatic logic [dss_pkg::BYTE_W-1:0] pick_char();
    int unsigned r;
    logic [dss_pkg::BYTE_W-1:0] c;
    r = $urandom_range(0, 99);
    c = 8'($urandom_range(0, 255));
    if (r < 20) return delim_reg[8*$urandom_range(0, MAX_DELIM-1) +: 8];
    if (r < ((mode_reg == dss_pkg::MODE_BLANK) ? 45 : 28))
      return $urandom_range(0, 1) ? dss_pkg::CH_SPACE : dss_pkg::CH_TAB;
    if (r < 55) return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
    return c;
  endfunction

  // Queue one string with scattered idle beats; return the beats queued
  function automatic int unsigned queue_random_string();
    char_beat_t                 str_q[$];
    char_beat_t                 cb;
    logic [dss_pkg::BYTE_W-1:0] junk;
    int unsigned                n;
    int unsigned                r;
    int unsigned                m;
    int unsigned                j;
    int unsigned                fed;
    r = $urandom_range(0, 99);
    n = (r < 70) ? $urandom_range(0, 12) : (r < 95) ? $urandom_range(13, 40)
                                                    : $urandom_range(41, 120);
    cb.present = 1'b1;
    cb.last    = 1'b0;
    while (str_q.size() < n) begin
      r = $urandom_range(0, 99);
      if (mode_reg == dss_pkg::MODE_LITERAL && r < 45) begin
        // Whole delimiter, or a prefix of it for near misses
        m = (r < 30) ? delim_width() : $urandom_range(1, delim_width());
        for (j = 0; j < m; j++) begin
          cb.data = delim_reg[8*j +: 8];
          str_q.push_back(cb);
        end
      end else begin
        cb.data = pick_char();
        str_q.push_back(cb);
      end
    end
    // End on the last byte, or with a bare end beat
    junk = 8'($urandom_range(0, 255));
    if (str_q.size() > 0 && $urandom_range(0, 99) < 60) begin
      str_q[str_q.size()-1].last = 1'b1;
    end else begin
      cb.data    = junk;
      cb.present = 1'b0;
      cb.last    = 1'b1;
      str_q.push_back(cb);
    end
    fed = 0;
    foreach (str_q[i]) begin
      junk = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 19) == 0) begin
        queue_beat(junk, 1'b0, 1'b0);
        fed++;
      end
      beat_q.push_back(str_q[i]);
      fed++;
    end
    return fed;
  endfunction

  // Wait until every beat is taken and every segment has come back
  task automatic settle();
    do @(posedge clk_i); while (beat_q.size() != 0 || in_valid_i);
    @(negedge clk_i);
    while (seg_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [dss_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [dss_pkg::CFG_DATA_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      dss_pkg::REG_SPLIT_MODE:  mode_reg = value[dss_pkg::MODE_W-1:0];
      dss_pkg::REG_DELIM_LEN:   dlen_reg = value[dss_pkg::DLEN_W-1:0];
      dss_pkg::REG_DELIM_BYTES: delim_reg = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : run_test
    logic [dss_pkg::CFG_DATA_W-1:0] cfg_word;
    logic [dss_pkg::BYTE_W-1:0]     c;
    logic [dss_pkg::MODE_W-1:0]     mode_pick;
    logic [dss_pkg::DLEN_W-1:0]     dlen_pick;
    int unsigned                    fed;
    int unsigned                    goal;
    int unsigned                    phase;
    int unsigned                    r;
    int                             i;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty string, an idle beat, then a one-byte zero delimiter
    queue_beat(8'hFF, 1'b0, 1'b1);
    queue_beat(8'hFF, 1'b0, 1'b0);
    queue_beat(8'h00, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b1, 1'b1);

    // Three-byte delimiter with overlapping candidates
    write_reg(dss_pkg::REG_SPLIT_MODE, {62'h0, dss_pkg::MODE_LITERAL});
    write_reg(dss_pkg::REG_DELIM_LEN, 64'd3);
    write_reg(dss_pkg::REG_DELIM_BYTES, {40'h0, CH_PERCENT, CH_LOWER_S, CH_PERCENT});
    queue_beat("a", 1'b1, 1'b0);
    queue_beat(CH_PERCENT, 1'b1, 1'b0);
    queue_beat(CH_LOWER_S, 1'b1, 1'b0);
    queue_beat(CH_PERCENT, 1'b1, 1'b0);
    queue_beat(CH_LOWER_S, 1'b1, 1'b0);
    queue_beat(CH_PERCENT, 1'b1, 1'b0);
    queue_beat("b", 1'b1, 1'b1);

    // Blanks, leading one included; the unused index must change nothing
    write_reg(REG_UNUSED, {$urandom, $urandom});
    write_reg(dss_pkg::REG_SPLIT_MODE, {62'h0, dss_pkg::MODE_BLANK});
    queue_beat(dss_pkg::CH_SPACE, 1'b1, 1'b0);
    queue_beat("x", 1'b1, 1'b0);
    queue_beat(dss_pkg::CH_TAB, 1'b1, 1'b0);
    queue_beat("y", 1'b1, 1'b1);

    // Per-byte mode, then the reserved mode code
    write_reg(dss_pkg::REG_SPLIT_MODE, {62'h0, dss_pkg::MODE_BYTE});
    queue_beat(8'hAA, 1'b1, 1'b0);
    queue_beat(8'h55, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b1);
    write_reg(dss_pkg::REG_SPLIT_MODE, {62'h0, MODE_RESERVED});
    queue_beat(8'h7E, 1'b1, 1'b1);

    // Random phases, each with its own register settings
    fed = 0;
    phase = 0;
    while (fed < RANDOM_BEATS) begin
      r = $urandom_range(0, 9);
      mode_pick = (r < 5) ? dss_pkg::MODE_LITERAL : (r < 7) ? dss_pkg::MODE_BLANK
                : (r < 9) ? dss_pkg::MODE_BYTE : MODE_RESERVED;
      if (phase < 5) mode_pick = dss_pkg::MODE_LITERAL;
      case (phase)
        0: dlen_pick = 4'd1;
        1: dlen_pick = 4'd8;
        2: dlen_pick = 4'd0;
        3: dlen_pick = 4'd15;
        4: dlen_pick = 4'd9;
        default: dlen_pick = 4'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                             : $urandom_range(0, 15));
      endcase
      if (phase == 1) begin
        cfg_word = '1;
      end else if (phase == 5) begin
        cfg_word = '0;
      end else begin
        // Random, one repeated byte, or a small alphabet
        r = $urandom_range(0, 2);
        c = 8'($urandom_range(0, 255));
        for (i = 0; i < MAX_DELIM; i++) begin
          case ($urandom_range(0, 3))
            0: cfg_word[8*i +: 8] = CH_PERCENT;
            1: cfg_word[8*i +: 8] = CH_LOWER_S;
            2: cfg_word[8*i +: 8] = dss_pkg::CH_SPACE;
            default: cfg_word[8*i +: 8] = "a";
          endcase
          if (r == 0) cfg_word[8*i +: 8] = 8'($urandom_range(0, 255));
          if (r == 1) cfg_word[8*i +: 8] = c;
        end
      end
      write_reg(dss_pkg::REG_DELIM_BYTES, cfg_word);
      cfg_word = {$urandom, $urandom};
      cfg_word[dss_pkg::DLEN_W-1:0] = dlen_pick;
      write_reg(dss_pkg::REG_DELIM_LEN, cfg_word);
      cfg_word = {$urandom, $urandom};
      cfg_word[dss_pkg::MODE_W-1:0] = mode_pick;
      write_reg(dss_pkg::REG_SPLIT_MODE, cfg_word);
      goal = fed + $urandom_range(110, 150);
      while (fed < goal) fed += queue_random_string();
      phase++;
    end

    // Per-byte cuts, then cut and end in blank mode
    write_reg(dss_pkg::REG_SPLIT_MODE, {62'h0, dss_pkg::MODE_BYTE});
    queue_beat(8'h31, 1'b1, 1'b0);
    queue_beat(8'h32, 1'b1, 1'b0);
    queue_beat(8'h33, 1'b1, 1'b0);
    write_reg(dss_pkg::REG_SPLIT_MODE, {62'h0, dss_pkg::MODE_BLANK});
    queue_beat(dss_pkg::CH_TAB, 1'b1, 1'b0);
    queue_beat(8'h34, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b1);
    queue_beat("a", 1'b1, 1'b0);
    queue_beat(dss_pkg::CH_SPACE, 1'b1, 1'b0);
    queue_beat("b", 1'b1, 1'b1);

    settle();
    if (bad_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
